[rtl/assert_macros.svh]
// Assertion macros shared by the calculator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/csc_pkg.sv]
// Shared types, codes and defaults of the checked stack calculator.
`default_nettype none
package csc_pkg;
    localparam int DefStackDepth = 64;
    localparam int DefNumVars    = 16;
    localparam int DataW         = 64;
    localparam int MdCntW        = 7;

    typedef enum logic [3:0] {
        CMD_PUSH  = 4'd0,
        CMD_PUSHV = 4'd1,
        CMD_POP   = 4'd2,
        CMD_PEEK  = 4'd3,
        CMD_PRINT = 4'd4,
        CMD_ABS   = 4'd5,
        CMD_PLUS  = 4'd6,
        CMD_MINUS = 4'd7,
        CMD_MUL   = 4'd8,
        CMD_DIV   = 4'd9
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FEW   = 3'd1,
        ST_OVF   = 3'd2,
        ST_DIV0  = 3'd3,
        ST_UNDEF = 3'd4,
        ST_FULL  = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_VREAD,
        S_OPREAD,
        S_EXEC,
        S_WAIT,
        S_FETCH,
        S_LOAD,
        S_DONE
    } state_t;

    // Request from the sequencer to the shared multiply/divide unit.
    typedef struct packed {
        logic             start;
        logic             is_div;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
    } md_req_t;

    // Answer of the multiply/divide unit.
    typedef struct packed {
        logic             done;
        logic             ovf;
        logic             div0;
        logic [DataW-1:0] result;
    } md_rsp_t;
endpackage
`default_nettype wire

[rtl/csc_muldiv.sv]
// Iterative signed 64-bit multiply and divide, one bit per cycle.
`default_nettype none
module csc_muldiv (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire csc_pkg::md_req_t req,
    output csc_pkg::md_rsp_t     rsp
);
    localparam int W = csc_pkg::DataW;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [csc_pkg::MdCntW-1:0] cnt_reg, cnt_next;
    logic              div_reg, div_next;
    logic              neg_reg, neg_next;
    logic              bz_reg, bz_next;
    logic [W-1:0]      mb_reg, mb_next;
    logic [W-1:0]      hi_reg, hi_next;
    logic [W-1:0]      lo_reg, lo_next;

    logic [W-1:0]      ma, mb;
    logic [W:0]        sum;
    logic [W:0]        opl, opr;

    // Take magnitudes of the operands
    assign ma = req.a[W-1] ? (~req.a + W'(1)) : req.a;
    assign mb = req.b[W-1] ? (~req.b + W'(1)) : req.b;

    // Share one 65-bit adder between the add step and the subtract step
    always_comb
    begin
        if (div_reg)
        begin
            opl = {hi_reg, lo_reg[W-1]};
            opr = ~{1'b0, mb_reg};
            sum = opl + opr + (W+1)'(1);
        end
        else
        begin
            opl = {1'b0, hi_reg};
            opr = lo_reg[0] ? {1'b0, mb_reg} : '0;
            sum = opl + opr;
        end
    end

    // Advance one step per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        bz_next   = bz_reg;
        mb_next   = mb_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            div_next  = req.is_div;
            neg_next  = req.a[W-1] ^ req.b[W-1];
            bz_next   = (req.b == '0);
            mb_next   = mb;
            hi_next   = '0;
            lo_next   = ma;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                hi_next = sum[W] ? opl[W-1:0] : sum[W-1:0];
                lo_next = {lo_reg[W-2:0], ~sum[W]};
            end
            else
            begin
                hi_next = sum[W:1];
                lo_next = {sum[0], lo_reg[W-1:1]};
            end
            cnt_next = cnt_reg + csc_pkg::MdCntW'(1);
            if (cnt_reg == csc_pkg::MdCntW'(W-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        neg_reg <= neg_next;
        bz_reg  <= bz_next;
        mb_reg  <= mb_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
    end

    // Check the range of the magnitude and apply the sign
    always_comb
    begin
        rsp.done   = done_reg;
        rsp.div0   = div_reg && bz_reg;
        rsp.result = neg_reg ? (~lo_reg + W'(1)) : lo_reg;
        if (div_reg)
            rsp.ovf = !neg_reg && lo_reg[W-1];
        else
            rsp.ovf = (hi_reg != '0) ||
                      (lo_reg[W-1] && (!neg_reg || (lo_reg[W-2:0] != '0)));
    end
endmodule
`default_nettype wire

[rtl/checked_stack_calculator_core.sv]
// Top level of the checked stack calculator: sequencer, stack and variable file.
// Usage: present cmd, literal and var_index with start high while busy is low;
// the command word is taken at that edge and busy rises. When the command is
// finished, done is high for exactly one cycle with status, printed and
// top_value (top of the stack after the command, zero when empty); the
// receiver cannot hold the result off, and busy falls at the edge ending it.
// Push variable of a defined slot first reads the variable RAM; a pop, an abs
// that overflows and a two-operand command that overflows or divides by zero
// reload the top from the stack RAM; plus, minus, mul and div first read the
// deeper operand, and mul and div then wait for the multiply/divide unit.
// The next command is taken in the cycle after done, so commands never
// overlap; mul and div are paced by the one-bit-per-cycle multiply/divide
// unit, and a stack entry below the cached top costs one read of the stack RAM.
// Reset empties the stack and marks every variable undefined; the stack and
// variable RAMs are not cleared.
`default_nettype none
module checked_stack_calculator_core #(
    parameter int STACK_DEPTH = csc_pkg::DefStackDepth,
    parameter int NUM_VARS    = csc_pkg::DefNumVars
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  cmd,
    input  wire logic signed [63:0] literal,
    input  wire logic [3:0]  var_index,
    output logic             done,
    output logic [2:0]       status,
    output logic             printed,
    output logic signed [63:0] top_value
);
    localparam int W  = csc_pkg::DataW;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int VW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

    csc_pkg::state_t  state_reg, state_next;
    csc_pkg::status_t st_reg, st_next;
    logic             pr_reg, pr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [W-1:0]     top_reg, top_next;
    logic [3:0]       cmd_reg;
    logic [W-1:0]     lit_reg;
    logic [3:0]       vi_reg;
    logic [NUM_VARS-1:0] def_reg, def_next;

    logic [W-1:0]     stack_mem [STACK_DEPTH];
    logic [W-1:0]     var_mem [NUM_VARS];
    logic [W-1:0]     st_rd_reg;
    logic [W-1:0]     var_rd_reg;
    logic             st_we;
    logic [AW-1:0]    st_wa;
    logic [W-1:0]     st_wd;
    logic [AW-1:0]    st_ra;
    logic             var_we;
    logic [VW-1:0]    vi_idx;
    logic             vi_ok;
    logic             full;

    csc_pkg::md_req_t md_req;
    csc_pkg::md_rsp_t md_rsp;

    logic             fin_go;
    logic             fin_ok;
    csc_pkg::status_t fin_st;
    logic [W-1:0]     fin_val;
    logic [W-1:0]     as_sum;
    logic             as_ovf;

    assign vi_idx = VW'(vi_reg);
    assign vi_ok  = (32'(vi_reg) < NUM_VARS);
    assign full   = (count_reg == CW'(STACK_DEPTH));

    csc_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // Add or subtract the deeper entry and the top
    always_comb
    begin
        if (cmd_reg == csc_pkg::CMD_MINUS)
        begin
            as_sum = st_rd_reg - top_reg;
            as_ovf = (st_rd_reg[W-1] != top_reg[W-1]) && (as_sum[W-1] != st_rd_reg[W-1]);
        end
        else
        begin
            as_sum = st_rd_reg + top_reg;
            as_ovf = (st_rd_reg[W-1] == top_reg[W-1]) && (as_sum[W-1] != st_rd_reg[W-1]);
        end
    end

    // Pick the finishing result of a two-operand command
    always_comb
    begin
        fin_go  = 1'b0;
        fin_val = as_sum;
        fin_st  = as_ovf ? csc_pkg::ST_OVF : csc_pkg::ST_OK;
        if (state_reg == csc_pkg::S_EXEC)
            fin_go = (cmd_reg == csc_pkg::CMD_PLUS) || (cmd_reg == csc_pkg::CMD_MINUS);
        else if (state_reg == csc_pkg::S_WAIT && md_rsp.done)
        begin
            fin_go  = 1'b1;
            fin_val = md_rsp.result;
            if (md_rsp.div0)
                fin_st = csc_pkg::ST_DIV0;
            else if (md_rsp.ovf)
                fin_st = csc_pkg::ST_OVF;
            else
                fin_st = csc_pkg::ST_OK;
        end
        fin_ok = (fin_st == csc_pkg::ST_OK);
    end

    // Sequence one command
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        pr_next    = pr_reg;
        count_next = count_reg;
        top_next   = top_reg;
        def_next   = def_reg;
        st_we      = 1'b0;
        st_wa      = count_reg[AW-1:0];
        st_wd      = lit_reg;
        st_ra      = AW'(count_reg - CW'(1));
        var_we     = 1'b0;
        md_req.start  = 1'b0;
        md_req.is_div = (cmd_reg == csc_pkg::CMD_DIV);
        md_req.a      = st_rd_reg;
        md_req.b      = top_reg;
        case (state_reg)
            csc_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = csc_pkg::S_DEC;
                    st_next    = csc_pkg::ST_OK;
                    pr_next    = 1'b0;
                end
            end
            csc_pkg::S_DEC:
            begin
                state_next = csc_pkg::S_DONE;
                case (cmd_reg)
                    csc_pkg::CMD_PUSH:
                    begin
                        if (full)
                            st_next = csc_pkg::ST_FULL;
                        else
                        begin
                            st_we      = 1'b1;
                            top_next   = lit_reg;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    csc_pkg::CMD_PUSHV:
                    begin
                        if (!vi_ok || !def_reg[vi_idx])
                            st_next = csc_pkg::ST_UNDEF;
                        else
                            state_next = csc_pkg::S_VREAD;
                    end
                    csc_pkg::CMD_POP:
                    begin
                        if (count_reg == '0)
                            st_next = csc_pkg::ST_FEW;
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = csc_pkg::S_FETCH;
                        end
                    end
                    csc_pkg::CMD_PEEK:
                    begin
                        if (count_reg == '0)
                            st_next = csc_pkg::ST_FEW;
                        else if (!vi_ok)
                            st_next = csc_pkg::ST_UNDEF;
                        else
                        begin
                            var_we           = 1'b1;
                            def_next[vi_idx] = 1'b1;
                        end
                    end
                    csc_pkg::CMD_PRINT:
                    begin
                        if (count_reg == '0)
                            st_next = csc_pkg::ST_FEW;
                        else
                            pr_next = 1'b1;
                    end
                    csc_pkg::CMD_ABS:
                    begin
                        if (count_reg == '0)
                            st_next = csc_pkg::ST_FEW;
                        else if (top_reg == {1'b1, {(W-1){1'b0}}})
                        begin
                            st_next    = csc_pkg::ST_OVF;
                            count_next = count_reg - CW'(1);
                            state_next = csc_pkg::S_FETCH;
                        end
                        else
                        begin
                            top_next = top_reg[W-1] ? (~top_reg + W'(1)) : top_reg;
                            st_we    = 1'b1;
                            st_wa    = AW'(count_reg - CW'(1));
                            st_wd    = top_next;
                        end
                    end
                    csc_pkg::CMD_PLUS, csc_pkg::CMD_MINUS,
                    csc_pkg::CMD_MUL, csc_pkg::CMD_DIV:
                    begin
                        if (count_reg < CW'(2))
                            st_next = csc_pkg::ST_FEW;
                        else
                            state_next = csc_pkg::S_OPREAD;
                    end
                    default:
                    begin
                        state_next = csc_pkg::S_DONE;
                    end
                endcase
            end
            csc_pkg::S_VREAD:
            begin
                state_next = csc_pkg::S_DONE;
                if (full)
                    st_next = csc_pkg::ST_FULL;
                else
                begin
                    st_we      = 1'b1;
                    st_wd      = var_rd_reg;
                    top_next   = var_rd_reg;
                    count_next = count_reg + CW'(1);
                end
            end
            csc_pkg::S_OPREAD:
            begin
                st_ra      = AW'(count_reg - CW'(2));
                state_next = csc_pkg::S_EXEC;
            end
            csc_pkg::S_EXEC:
            begin
                if (!fin_go)
                begin
                    md_req.start = 1'b1;
                    state_next   = csc_pkg::S_WAIT;
                end
            end
            csc_pkg::S_WAIT:
            begin
                state_next = csc_pkg::S_WAIT;
            end
            csc_pkg::S_FETCH:
            begin
                state_next = csc_pkg::S_LOAD;
            end
            csc_pkg::S_LOAD:
            begin
                if (count_reg != '0)
                    top_next = st_rd_reg;
                state_next = csc_pkg::S_DONE;
            end
            csc_pkg::S_DONE:
            begin
                state_next = csc_pkg::S_IDLE;
            end
            default:
            begin
                state_next = csc_pkg::S_IDLE;
            end
        endcase

        // Push the result over both operands, or drop both
        if (fin_go)
        begin
            st_next = fin_st;
            if (fin_ok)
            begin
                st_we      = 1'b1;
                st_wa      = AW'(count_reg - CW'(2));
                st_wd      = fin_val;
                top_next   = fin_val;
                count_next = count_reg - CW'(1);
                state_next = csc_pkg::S_DONE;
            end
            else
            begin
                count_next = count_reg - CW'(2);
                state_next = csc_pkg::S_FETCH;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csc_pkg::S_IDLE;
            count_reg <= '0;
            def_reg   <= '0;
            st_reg    <= csc_pkg::ST_OK;
            pr_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            def_reg   <= def_next;
            st_reg    <= st_next;
            pr_reg    <= pr_next;
        end
    end

    // Capture the command word and the cached top
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (state_reg == csc_pkg::S_IDLE && start)
        begin
            cmd_reg <= cmd;
            lit_reg <= literal;
            vi_reg  <= var_index;
        end
    end

    // Stack RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (st_we)
            stack_mem[st_wa] <= st_wd;
        st_rd_reg <= stack_mem[st_ra];
    end

    // Variable RAM: written by peek, read for push variable
    always_ff @(posedge clk)
    begin
        if (var_we)
            var_mem[vi_idx] <= top_reg;
        var_rd_reg <= var_mem[vi_idx];
    end

    assign busy      = (state_reg != csc_pkg::S_IDLE);
    assign done      = (state_reg == csc_pkg::S_DONE);
    assign status    = st_reg;
    assign printed   = pr_reg;
    assign top_value = (count_reg == '0) ? '0 : top_reg;

`include "assert_macros.svh"
    `ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CW'(STACK_DEPTH))
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)
    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done && !busy)
    `ASSERT_ALWAYS(a_md_start_exec, clk, rst_n, !md_req.start || state_reg == csc_pkg::S_EXEC)
    `ASSERT_ALWAYS(a_print_ok, clk, rst_n, !(done && printed) || (status == csc_pkg::ST_OK && count_reg != '0))
endmodule
`default_nettype wire

[tb/checked_stack_calculator_checker.sv]
// Checker for the stack calculator: predicts each result word and compares it.
module checked_stack_calculator_checker
    import csc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [3:0]         cmd,
    input  wire logic signed [63:0] literal,
    input  wire logic [3:0]         var_index,
    input  wire logic               done,
    input  wire logic [2:0]         status,
    input  wire logic               printed,
    input  wire logic signed [63:0] top_value,
    output int                      fail_count,
    output int                      pending_count,
    output int                      status_seen [6]
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MaxVal = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        status_t     st;
        logic        prn;
        logic [63:0] top;
    } calc_word_t;

    logic [63:0] stack_mem [DefStackDepth];
    int          depth;
    logic [63:0] var_mem [DefNumVars];
    logic        var_valid [DefNumVars];
    calc_word_t  expected_words [$];

    assign pending_count = expected_words.size();

    function automatic logic [63:0] mag(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    // Work out status and value of a two-operand command; a is deeper.
    function automatic status_t arith(cmd_t c, logic [63:0] a, logic [63:0] b,
                                      output logic [63:0] res);
        logic [63:0]  s;
        logic [127:0] prod;
        logic         neg;
        neg = a[63] ^ b[63];
        res = '0;
        case (c)
            CMD_PLUS:
            begin
                s = a + b;
                if (a[63] == b[63] && s[63] != a[63]) return ST_OVF;
                res = s;
            end
            CMD_MINUS:
            begin
                s = a - b;
                if (a[63] != b[63] && s[63] != a[63]) return ST_OVF;
                res = s;
            end
            CMD_MUL:
            begin
                prod = {64'd0, mag(a)} * {64'd0, mag(b)};
                if (prod > {64'd0, (neg ? MinVal : MaxVal)}) return ST_OVF;
                res = neg ? -prod[63:0] : prod[63:0];
            end
            default:
            begin
                if (b == 0) return ST_DIV0;
                s = mag(a) / mag(b);
                if (!neg && s > MaxVal) return ST_OVF;
                res = neg ? -s : s;
            end
        endcase
        return ST_OK;
    endfunction

    // Advance the predicted calculator by one command word.
    function automatic calc_word_t run_command(logic [3:0] c, logic [63:0] lit,
                                               logic [3:0] vi);
        calc_word_t  w;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        w.st = ST_OK;
        w.prn = 1'b0;
        case (c)
            CMD_PUSH:
                if (depth >= DefStackDepth) w.st = ST_FULL;
                else stack_mem[depth++] = lit;
            CMD_PUSHV:
                if (!var_valid[vi]) w.st = ST_UNDEF;
                else if (depth >= DefStackDepth) w.st = ST_FULL;
                else stack_mem[depth++] = var_mem[vi];
            CMD_POP:
                if (depth < 1) w.st = ST_FEW;
                else depth--;
            CMD_PEEK:
                if (depth < 1) w.st = ST_FEW;
                else
                begin
                    var_mem[vi] = stack_mem[depth-1];
                    var_valid[vi] = 1'b1;
                end
            CMD_PRINT:
                if (depth < 1) w.st = ST_FEW;
                else w.prn = 1'b1;
            CMD_ABS:
                if (depth < 1) w.st = ST_FEW;
                else if (stack_mem[depth-1] == MinVal)
                begin
                    w.st = ST_OVF;
                    depth--;
                end
                else stack_mem[depth-1] = mag(stack_mem[depth-1]);
            CMD_PLUS, CMD_MINUS, CMD_MUL, CMD_DIV:
                if (depth < 2) w.st = ST_FEW;
                else
                begin
                    b = stack_mem[depth-1];
                    a = stack_mem[depth-2];
                    depth -= 2;
                    w.st = arith(cmd_t'(c), a, b, r);
                    if (w.st == ST_OK) stack_mem[depth++] = r;
                end
            default: ;
        endcase
        w.top = (depth > 0) ? stack_mem[depth-1] : '0;
        return w;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
    end

    // Predict on accepted commands, compare on every done strobe.
    always @(posedge clk or negedge rst_n)
    begin
        calc_word_t w;
        if (!rst_n)
        begin
            depth = 0;
            foreach (var_valid[i]) var_valid[i] = 1'b0;
            expected_words.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    w = expected_words.pop_front();
                    if (status !== w.st)
                        report_mismatch($sformatf("status %0d, want %0d", status, w.st));
                    if (printed !== w.prn)
                        report_mismatch($sformatf("printed %0b, want %0b", printed, w.prn));
                    if (top_value !== w.top)
                        report_mismatch($sformatf("top_value %h, want %h",
                                                  top_value, w.top));
                    if (w.st <= ST_FULL) status_seen[w.st]++;
                end
            end
            if (start && !busy)
                expected_words.push_back(run_command(cmd, literal, var_index));
        end
    end
endmodule

[tb/checked_stack_calculator_core_tb.sv]
// Testbench top: drives command words into the calculator and gives the verdict.
module checked_stack_calculator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import csc_pkg::*;

    localparam int WatchdogLimit = 2000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [3:0]         cmd = '0;
    logic signed [63:0] literal = '0;
    logic [3:0]         var_index = '0;
    logic               busy;
    logic               done;
    logic [2:0]         status;
    logic               printed;
    logic signed [63:0] top_value;
    int                 fail_count;
    int                 pending_count;
    int                 status_seen [6];
    int                 idle_pct;
    int                 stuck_cycles;
    int                 words_sent;
    int                 model_depth;
    logic [15:0]        peeked;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    checked_stack_calculator_core i_dut (
        .clk, .rst_n, .start, .busy, .cmd, .literal, .var_index,
        .done, .status, .printed, .top_value
    );

    checked_stack_calculator_checker i_checker (
        .clk, .rst_n, .start, .busy, .cmd, .literal, .var_index,
        .done, .status, .printed, .top_value,
        .fail_count, .pending_count, .status_seen
    );

    // Count cycles without progress; end the run when the block hangs.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n) stuck_cycles <= 0;
        else stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WatchdogLimit)
        begin
            $display("watchdog expired after %0d idle cycles", WatchdogLimit);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return 64'hFFFF_FFFF_FFFF_FFFF;
            3: return 64'd0;
            4: return 64'd1;
            5, 6: return 64'($signed($urandom_range(0, 200)) - 100);
            7: return {32'(0 - $urandom_range(0, 1)), $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Send one command word and hold until the block takes it.
    task automatic send_word(cmd_t c, logic [63:0] lit, logic [3:0] vi);
        while (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct)
            @(posedge clk);
        start <= 1'b1;
        cmd <= c;
        literal <= lit;
        var_index <= vi;
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b0;
        cmd <= 4'($urandom());
        literal <= {$urandom(), $urandom()};
        words_sent++;
        // Track depth roughly so pushes do not pile up; exactness is not needed.
        if (c == CMD_PUSH || c == CMD_PUSHV) model_depth++;
        else if (c == CMD_POP || c >= CMD_PLUS) model_depth--;
        if (model_depth < 0) model_depth = 0;
        if (model_depth > DefStackDepth) model_depth = DefStackDepth;
        if (c == CMD_PEEK) peeked[vi] = 1'b1;
        // Keep start low in the cycle the command finishes.
        while (!done) @(posedge clk);
    endtask

    task automatic send_random();
        int          pick;
        logic [3:0]  vi;
        pick = $urandom_range(0, 99);
        vi = 4'($urandom());
        if (pick < 4) send_word(cmd_t'(4'($urandom_range(10, 15))), rand_value(), vi);
        else if (pick < 30 && model_depth < 40) send_word(CMD_PUSH, rand_value(), vi);
        else if (pick < 38) send_word(CMD_PUSHV, rand_value(),
                                      (peeked[vi] || $urandom_range(0, 3) == 0) ? vi : 4'd0);
        else if (pick < 44) send_word(CMD_POP, rand_value(), vi);
        else if (pick < 52) send_word(CMD_PEEK, rand_value(), vi);
        else if (pick < 56) send_word(CMD_PRINT, rand_value(), vi);
        else if (pick < 62) send_word(CMD_ABS, rand_value(), vi);
        else send_word(cmd_t'(4'($urandom_range(6, 9))), rand_value(), vi);
    endtask

    initial
    begin
        int   i;
        idle_pct = 0;
        words_sent = 0;
        model_depth = 0;
        peeked = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-stack errors, undefined variables, extremes.
        for (i = 2; i <= 9; i++) send_word(cmd_t'(i), '0, 4'd0);
        send_word(CMD_PUSHV, '0, 4'd7);
        send_word(CMD_PUSH, 64'h8000_0000_0000_0000, 4'd0);
        send_word(CMD_PEEK, '0, 4'd15);
        send_word(CMD_ABS, '0, 4'd0);
        send_word(CMD_PUSHV, '0, 4'd15);
        send_word(CMD_PUSHV, '0, 4'd15);
        send_word(CMD_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
        send_word(CMD_DIV, '0, 4'd0);
        send_word(CMD_PUSH, 64'h7FFF_FFFF_FFFF_FFFF, 4'd0);
        send_word(CMD_PUSH, 64'd1, 4'd0);
        send_word(CMD_PLUS, '0, 4'd0);
        send_word(CMD_PUSH, 64'd5, 4'd0);
        send_word(CMD_PUSH, 64'd0, 4'd0);
        send_word(CMD_DIV, '0, 4'd0);
        send_word(CMD_PUSH, -64'd7, 4'd0);
        send_word(CMD_PUSH, 64'd2, 4'd0);
        send_word(CMD_DIV, '0, 4'd0);
        send_word(CMD_PRINT, '0, 4'd0);
        send_word(cmd_t'(4'd15), '0, 4'd0);
        model_depth = 1;

        // Fill to the top to reach the stack-full case, then drain.
        for (i = 0; i < DefStackDepth + 1; i++) send_word(CMD_PUSH, rand_value(), 4'd3);
        send_word(CMD_PUSHV, '0, 4'd15);
        repeat (DefStackDepth + 2) send_word(CMD_POP, '0, 4'd0);
        model_depth = 0;

        // Random phases with different sender idling.
        for (i = 0; i < 1500; i++)
        begin
            case (i / 300)
                0, 3: idle_pct = 0;
                1: idle_pct = 47;
                2: idle_pct = 9;
                default: idle_pct = $urandom_range(0, 1) ? 47 : 0;
            endcase
            send_random();
        end

        while (pending_count != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("sent %0d command words; ok %0d, few %0d, ovf %0d, div0 %0d",
                 words_sent, status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3]);
        $display("undefined-variable %0d, stack-full %0d", status_seen[4], status_seen[5]);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
